>>> sv/wvp_pkg.sv
// Shared constants, types and register codes for the wheel velocity PI regulator.
package wvp_pkg;

  // Field widths
  localparam int TickWidth  = 16;
  localparam int CountBits  = 16;
  localparam int SpeedWidth = 8;
  localparam int GainWidth  = 16;
  localparam int ErrWidth   = 17;
  localparam int SumWidth   = 32;
  localparam int PropWidth  = 17;
  localparam int DriveWidth = 8;

  // Only the low CountBits bits of the tick count take part
  localparam logic [TickWidth-1:0] CountMask = (CountBits >= TickWidth) ?
      {TickWidth{1'b1}} : TickWidth'((64'd1 << CountBits) - 64'd1);

  // Shared divider geometry: radix-16, four restoring steps per cycle
  localparam int QuoWidth  = 40;
  localparam int DigitBits = 4;
  localparam int Digits    = QuoWidth / DigitBits;
  localparam int CntWidth  = $clog2(Digits + 1);

  // Widths of the scaled quotients and their sum
  localparam int PdWidth     = 27;   // |err| * 1000 < 2^26
  localparam int IdWidth     = 39;   // |sum| * 100 < 2^38
  localparam int DrvSumWidth = 40;

  // Loop constants
  localparam int SumCap       = 4000;
  localparam int PropScale    = 1000;
  localparam int IntegScale   = 100;
  localparam int DriveMax     = 250;
  localparam int DriveOver    = 100;
  localparam int SetpointFull = 200;
  localparam int SpeedFull    = 255;
  localparam int PropReset    = 1500;
  localparam int IntegReset   = 10000;

  // Register indexes (byte address / 4)
  localparam logic [1:0] RegEnable = 2'd0;
  localparam logic [1:0] RegSpeed  = 2'd1;
  localparam logic [1:0] RegProp   = 2'd2;
  localparam logic [1:0] RegInteg  = 2'd3;

  typedef struct packed {
    logic                  enable;
    logic [SpeedWidth-1:0] speed;
    logic [GainWidth-1:0]  prop_div;
    logic [GainWidth-1:0]  integ_div;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [QuoWidth-1:0]  dividend;
    logic [GainWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [QuoWidth-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [DriveWidth-1:0]      drive;
    logic signed [PropWidth-1:0] prop;
    logic signed [SumWidth-1:0]  integ;
  } res_t;

endpackage

>>> sv/wvp_divider.sv
// Shared iterative unsigned divider, four quotient bits per cycle.
module wvp_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  wvp_pkg::div_req_t  req,
  output wvp_pkg::div_rsp_t  rsp
);

  logic [wvp_pkg::QuoWidth-1:0]  quo_r, quo_nxt;
  logic [wvp_pkg::GainWidth-1:0] rem_r, rem_nxt;
  logic [wvp_pkg::GainWidth-1:0] dvs_r;
  logic [wvp_pkg::CntWidth-1:0]  cnt_r;
  logic                          done_r;

  // One radix-16 digit: four restoring shift/subtract steps
  always_comb begin
    logic [wvp_pkg::GainWidth:0]   part;
    logic [wvp_pkg::GainWidth-1:0] rem_v;
    logic [wvp_pkg::QuoWidth-1:0]  quo_v;
    rem_v = rem_r;
    quo_v = quo_r;
    part  = '0;
    for (int i = 0; i < wvp_pkg::DigitBits; i++) begin
      part  = {rem_v, quo_v[wvp_pkg::QuoWidth-1]};
      quo_v = {quo_v[wvp_pkg::QuoWidth-2:0], 1'b0};
      if (part >= {1'b0, dvs_r}) begin
        part     = part - {1'b0, dvs_r};
        quo_v[0] = 1'b1;
      end
      rem_v = part[wvp_pkg::GainWidth-1:0];
    end
    rem_nxt = rem_v;
    quo_nxt = quo_v;
  end

  // Digit counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= wvp_pkg::CntWidth'(wvp_pkg::Digits);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == wvp_pkg::CntWidth'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient shifts in over the dividend
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

>>> sv/wvp_core.sv
// Sequencer for one PI step: setpoint, error sum, and five divisions on the shared divider.
module wvp_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_accept,
  input  logic [wvp_pkg::TickWidth-1:0] tick_count,
  input  wvp_pkg::cfg_t      cfg,
  input  logic               res_take,
  output logic               ready,
  output logic               res_valid,
  output wvp_pkg::res_t      res,
  output wvp_pkg::div_req_t  div_req,
  input  wvp_pkg::div_rsp_t  div_rsp
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SETP = 4'd1;
  localparam logic [3:0] S_PREP = 4'd2;
  localparam logic [3:0] S_PT   = 4'd3;
  localparam logic [3:0] S_PD   = 4'd4;
  localparam logic [3:0] S_IT   = 4'd5;
  localparam logic [3:0] S_ID   = 4'd6;
  localparam logic [3:0] S_DRV  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state_r, state_nxt;

  logic [wvp_pkg::TickWidth-1:0]       count_r;
  logic signed [wvp_pkg::SumWidth-1:0] sum_r;
  logic                                err_neg_r, sum_neg_r;
  logic [wvp_pkg::GainWidth-1:0]       err_mag_r;
  logic [wvp_pkg::SumWidth-1:0]        sum_mag_r;
  logic signed [wvp_pkg::PdWidth-1:0]  pd_r;
  logic signed [wvp_pkg::IdWidth-1:0]  id_r;
  logic signed [wvp_pkg::PropWidth-1:0] prop_r;
  logic signed [wvp_pkg::SumWidth-1:0] integ_r;
  logic [wvp_pkg::DriveWidth-1:0]      drive_r;

  logic [wvp_pkg::GainWidth-1:0] kp, ki;
  logic [wvp_pkg::SpeedWidth-1:0] setpoint;
  logic signed [wvp_pkg::ErrWidth-1:0]   err;
  logic signed [wvp_pkg::ErrWidth-1:0]   err_abs;
  logic signed [wvp_pkg::SumWidth:0]     sum_wide;
  logic signed [wvp_pkg::SumWidth-1:0]   sum_sat;
  logic signed [wvp_pkg::SumWidth:0]     sum_abs;
  logic signed [wvp_pkg::QuoWidth:0]     q_mag, q_val;
  logic                                  q_neg;
  logic signed [wvp_pkg::DrvSumWidth-1:0] drive_sum;
  logic [wvp_pkg::DriveWidth-1:0]         drive_clamped;

  // A zero divisor acts as one
  assign kp = (cfg.prop_div == '0) ? wvp_pkg::GainWidth'(1) : cfg.prop_div;
  assign ki = (cfg.integ_div == '0) ? wvp_pkg::GainWidth'(1) : cfg.integ_div;

  // Error and saturated running sum once the setpoint is known
  always_comb begin
    setpoint = div_rsp.quotient[wvp_pkg::SpeedWidth-1:0];
    err      = $signed({9'd0, setpoint}) - $signed({1'b0, count_r});
    err_abs  = err[wvp_pkg::ErrWidth-1] ? -err : err;
    sum_wide = $signed({sum_r[wvp_pkg::SumWidth-1], sum_r})
             + (wvp_pkg::SumWidth+1)'(err);
    if (sum_wide > (wvp_pkg::SumWidth+1)'(wvp_pkg::SumCap)) begin
      sum_sat = wvp_pkg::SumWidth'(wvp_pkg::SumCap);
    end else if (sum_wide < $signed({2'b11, {(wvp_pkg::SumWidth-1){1'b0}}})) begin
      sum_sat = $signed({1'b1, {(wvp_pkg::SumWidth-1){1'b0}}});
    end else begin
      sum_sat = sum_wide[wvp_pkg::SumWidth-1:0];
    end
    sum_abs = sum_sat[wvp_pkg::SumWidth-1] ? -(wvp_pkg::SumWidth+1)'(sum_sat)
                                           : (wvp_pkg::SumWidth+1)'(sum_sat);
  end

  // Sign restore on the unsigned quotient (truncation toward zero)
  always_comb begin
    q_neg = (state_r == S_PT || state_r == S_PD) ? err_neg_r : sum_neg_r;
    q_mag = $signed({1'b0, div_rsp.quotient});
    q_val = q_neg ? -q_mag : q_mag;
  end

  // Drive sum and clamp
  always_comb begin
    drive_sum = wvp_pkg::DrvSumWidth'(pd_r) + wvp_pkg::DrvSumWidth'(id_r);
    if (drive_sum < 0) begin
      drive_clamped = '0;
    end else if (drive_sum > wvp_pkg::DrvSumWidth'(wvp_pkg::DriveMax)) begin
      drive_clamped = wvp_pkg::DriveWidth'(wvp_pkg::DriveOver);
    end else begin
      drive_clamped = drive_sum[wvp_pkg::DriveWidth-1:0];
    end
  end

  // Sequencer and divider requests
  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_r)
      S_IDLE: begin
        if (in_accept && cfg.enable) begin
          div_req.start    = 1'b1;
          div_req.dividend = wvp_pkg::QuoWidth'(cfg.speed)
                           * wvp_pkg::QuoWidth'(wvp_pkg::SetpointFull);
          div_req.divisor  = wvp_pkg::GainWidth'(wvp_pkg::SpeedFull);
          state_nxt        = S_SETP;
        end
      end
      S_SETP: begin
        if (div_rsp.done) begin
          state_nxt = (setpoint == '0) ? S_IDLE : S_PREP;
        end
      end
      S_PREP: begin
        div_req.start    = 1'b1;
        div_req.dividend = wvp_pkg::QuoWidth'(err_mag_r);
        div_req.divisor  = kp;
        state_nxt        = S_PT;
      end
      S_PT: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = wvp_pkg::QuoWidth'(err_mag_r)
                           * wvp_pkg::QuoWidth'(wvp_pkg::PropScale);
          div_req.divisor  = kp;
          state_nxt        = S_PD;
        end
      end
      S_PD: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = wvp_pkg::QuoWidth'(sum_mag_r);
          div_req.divisor  = ki;
          state_nxt        = S_IT;
        end
      end
      S_IT: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = wvp_pkg::QuoWidth'(sum_mag_r)
                           * wvp_pkg::QuoWidth'(wvp_pkg::IntegScale);
          div_req.divisor  = ki;
          state_nxt        = S_ID;
        end
      end
      S_ID: begin
        if (div_rsp.done) begin
          state_nxt = S_DRV;
        end
      end
      S_DRV: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and the running error sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SETP && div_rsp.done && setpoint != '0) begin
        sum_r <= sum_sat;
      end
    end
  end

  // Payload captures
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_accept) begin
      count_r <= tick_count & wvp_pkg::CountMask;
    end
    if (state_r == S_SETP && div_rsp.done) begin
      err_neg_r <= err[wvp_pkg::ErrWidth-1];
      err_mag_r <= err_abs[wvp_pkg::GainWidth-1:0];
      sum_neg_r <= sum_sat[wvp_pkg::SumWidth-1];
      sum_mag_r <= sum_abs[wvp_pkg::SumWidth-1:0];
    end
    if (div_rsp.done) begin
      case (state_r)
        S_PT:    prop_r  <= q_val[wvp_pkg::PropWidth-1:0];
        S_PD:    pd_r    <= q_val[wvp_pkg::PdWidth-1:0];
        S_IT:    integ_r <= q_val[wvp_pkg::SumWidth-1:0];
        S_ID:    id_r    <= q_val[wvp_pkg::IdWidth-1:0];
        default: ;
      endcase
    end
    if (state_r == S_DRV) begin
      drive_r <= drive_clamped;
    end
  end

  assign ready     = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res.drive = drive_r;
  assign res.prop  = prop_r;
  assign res.integ = integ_r;

  // Divider completes only while a division is awaited
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_SETP || state_r == S_PT || state_r == S_PD ||
                      state_r == S_IT || state_r == S_ID))
    else $error("divider done outside a wait state");

  // Error sum moves only when a step commits
  a_sum_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> $stable(sum_r))
    else $error("error sum changed from idle");

  // Running sum stays at or below its cap
  a_sum_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PREP) |-> (sum_r <= wvp_pkg::SumWidth'(wvp_pkg::SumCap)))
    else $error("error sum above cap");

  // Clamped drive never exceeds its ceiling
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res.drive <= wvp_pkg::DriveWidth'(wvp_pkg::DriveMax)))
    else $error("drive out of range");

  // A waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_take) |=> (res_valid && $stable(res)))
    else $error("pending result dropped or changed");

endmodule

>>> sv/wheel_velocity_pi_regulator_unit.sv
// Top level: register port, stream handshakes, result register, core and divider.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------------
//  in_      | request   | in_tvalid / in_tready      | in_tdata: tick_count
//  out_     | result    | out_tvalid / out_tready    | out_tdata: drive, prop, integ
//  cfg_     | registers | psel, penable, pwrite      | paddr, pwdata, prdata
//
// From acceptance to result, a request passes through five divisions on
// the shared radix-16 divider (setpoint, both proportional and both integral
// quotients) and the control states between them.
// in_tready is high only while the sequencer is idle; a disabled loop or a zero
// setpoint retires the request with no result.
// The result register frees the sequencer as soon as its result is loaded;
// a stalled out_tready holds both the register and, once it is full, the sequencer.
// Reset (synchronous, active low) clears the error sum and the registers to their
// reset values.
module wheel_velocity_pi_regulator_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] tick_count
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [7:0] drive_value, [24:8] prop_term,
                                   // [56:25] integ_term, [63:57] zero
  // Register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  wvp_pkg::cfg_t     cfg_r;
  wvp_pkg::div_req_t div_req;
  wvp_pkg::div_rsp_t div_rsp;
  wvp_pkg::res_t     res;
  wvp_pkg::res_t     out_r;
  logic              out_valid_r;
  logic              core_ready;
  logic              res_valid;
  logic              res_take;
  logic              in_accept;
  logic              cfg_write;
  logic [1:0]        cfg_index;

  assign cfg_pready = 1'b1;
  assign cfg_index  = cfg_paddr[3:2];
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable    <= 1'b0;
      cfg_r.speed     <= '0;
      cfg_r.prop_div  <= wvp_pkg::GainWidth'(wvp_pkg::PropReset);
      cfg_r.integ_div <= wvp_pkg::GainWidth'(wvp_pkg::IntegReset);
    end else if (cfg_write) begin
      case (cfg_index)
        wvp_pkg::RegEnable: cfg_r.enable    <= cfg_pwdata[0];
        wvp_pkg::RegSpeed:  cfg_r.speed     <= cfg_pwdata[wvp_pkg::SpeedWidth-1:0];
        wvp_pkg::RegProp:   cfg_r.prop_div  <= cfg_pwdata[wvp_pkg::GainWidth-1:0];
        wvp_pkg::RegInteg:  cfg_r.integ_div <= cfg_pwdata[wvp_pkg::GainWidth-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (cfg_index)
      wvp_pkg::RegEnable: cfg_prdata = {31'd0, cfg_r.enable};
      wvp_pkg::RegSpeed:  cfg_prdata = 32'(cfg_r.speed);
      wvp_pkg::RegProp:   cfg_prdata = 32'(cfg_r.prop_div);
      wvp_pkg::RegInteg:  cfg_prdata = 32'(cfg_r.integ_div);
      default:            cfg_prdata = '0;
    endcase
  end

  assign in_tready = core_ready;
  assign in_accept = in_tvalid && core_ready;

  // Result register between the sequencer and the output stream
  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r.integ, out_r.prop, out_r.drive};

  wvp_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  wvp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .tick_count (in_tdata),
    .cfg        (cfg_r),
    .res_take   (res_take),
    .ready      (core_ready),
    .res_valid  (res_valid),
    .res        (res),
    .div_req    (div_req),
    .div_rsp    (div_rsp)
  );

endmodule
